// File: src/assert_macros.svh
// Assertion macros used by the checker file of the minimum filter.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define MFZ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define MFZ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked through reset.
`define MFZ_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mfz_pkg.sv
// Shared types, constants and helpers of the zero-border minimum filter.
// Depends on nothing; the source files that use it refer to it by scoped names.
package mfz_pkg;

   localparam int DATA_W = 16;
   localparam int ROW_W = 10;
   localparam int COL_W = 10;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 11;
   localparam int WIDTH_REG_W = 11;
   localparam int HEIGHT_REG_W = 11;
   localparam int SIZE_REG_W = 5;
   localparam int ANCHOR_REG_W = 4;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_KERNEL = 16;

   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 11'd1024;
   localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 5'd3;
   localparam logic [ANCHOR_REG_W-1:0] ANCHOR_RESET = 4'd1;

   localparam logic signed [DATA_W-1:0] ONE_Q14 = 16'sd16384;
   localparam logic signed [DATA_W-1:0] ZERO_Q14 = 16'sd0;
   localparam logic signed [DATA_W-1:0] TOP_Q14 = 16'sh7fff;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_WIDTH = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_WINDOW_SIZE = 2'd2,
      REG_WINDOW_ANCHOR = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic push;
      logic row_start;
   } chain_ctrl_type;

   typedef struct packed {
      logic last_pixel;
      logic [COL_W-1:0] out_column;
      logic [ROW_W-1:0] out_row;
      logic signed [DATA_W-1:0] out_value;
   } out_item_type;

   function automatic logic signed [DATA_W-1:0] min_q14(
      input logic signed [DATA_W-1:0] a,
      input logic signed [DATA_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

// File: src/mfz_cell.sv
// One cell of the horizontal minimum chain: holds the minimum of a window
// that is one sample longer than its left neighbour's. Uses mfz_pkg.
module mfz_cell (
   input  logic clock,
   input  logic push,
   input  logic signed [mfz_pkg::DATA_W-1:0] sample,
   input  logic signed [mfz_pkg::DATA_W-1:0] neighbour,
   output logic signed [mfz_pkg::DATA_W-1:0] value_in,
   output logic signed [mfz_pkg::DATA_W-1:0] value_ff
);

   assign value_in = mfz_pkg::min_q14(sample, neighbour);

   always_ff @(posedge clock) begin
      if (push) begin
         value_ff <= value_in;
      end
   end

endmodule

// File: src/mfz_row_chain.sv
// Row of mfz_cell instances forming the running horizontal window minimum.
// Depends on mfz_pkg and mfz_cell.
module mfz_row_chain #(
   parameter int MAX_KERNEL = mfz_pkg::DEF_MAX_KERNEL,
   parameter int KW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1
) (
   input  logic clock,
   input  mfz_pkg::chain_ctrl_type ctrl,
   input  logic signed [mfz_pkg::DATA_W-1:0] sample,
   input  logic [KW-1:0] length_sel,
   output logic signed [mfz_pkg::DATA_W-1:0] result
);

   logic signed [mfz_pkg::DATA_W-1:0] value_in [MAX_KERNEL];
   logic signed [mfz_pkg::DATA_W-1:0] value_ff [MAX_KERNEL];
   logic signed [mfz_pkg::DATA_W-1:0] neighbour [MAX_KERNEL];

   for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_cell
      if (j == 0) begin : g_first
         assign neighbour[j] = mfz_pkg::TOP_Q14;
      end else begin : g_rest
         // At the start of a row everything left of the image reads as zero.
         assign neighbour[j] = ctrl.row_start ? mfz_pkg::ZERO_Q14 : value_ff[j-1];
      end
      mfz_cell u_cell (
         .clock    (clock),
         .push     (ctrl.push),
         .sample   (sample),
         .neighbour(neighbour[j]),
         .value_in (value_in[j]),
         .value_ff (value_ff[j])
      );
   end

   assign result = value_in[length_sel];

endmodule

// File: src/mfz_ram.sv
// Generic single-port-write, single-port-read memory with registered read.
// Depends on nothing.
module mfz_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// File: src/mfz_out_fifo.sv
// Result queue between the filter core and the rsp_ channel.
// Depends on mfz_pkg for the result item type.
module mfz_out_fifo #(
   parameter int DEPTH = 32,
   parameter int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  mfz_pkg::out_item_type push_item,
   input  logic pop_ready,
   output logic head_valid,
   output mfz_pkg::out_item_type head_item,
   output logic [CNT_W-1:0] count
);

   mfz_pkg::out_item_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic pop;

   assign head_valid = (count_ff != '0);
   assign head_item = entries_ff[rptr_ff];
   assign count = count_ff;
   assign pop = head_valid && pop_ready;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wptr_ff] <= push_item;
      end
   end

endmodule

// File: src/min_filter_2d_zero_border.sv
// Zero-border square minimum filter (erosion) on a raster pixel stream.
// After the last pixel of a row, window_size-1-anchor zero samples are pushed through
// the horizontal cell chain while req_tready is low. A result passes the line store
// read register and then the output queue before it reaches rsp_.
// Reset is synchronous: registers return to their defaults and the stream restarts.
module min_filter_2d_zero_border #(
   parameter int MAX_WIDTH = mfz_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mfz_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_KERNEL = mfz_pkg::DEF_MAX_KERNEL
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [mfz_pkg::REQ_TDATA_W-1:0] req_tdata,  // [15:0] sample
   input  logic [0:0] req_tuser,                       // [0] kind
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [15:0] out_value, [25:16] out_row, [35:26] out_column, [39:36] zero
   output logic [mfz_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic rsp_tlast,                             // last_pixel
   input  logic csr_write_enable,
   input  logic [mfz_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mfz_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int KCW = $clog2(MAX_KERNEL + 1);
   localparam int KW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int PW = $clog2(MAX_WIDTH + MAX_KERNEL + 1);
   localparam int DW = mfz_pkg::DATA_W;
   localparam int VEC_W = MAX_KERNEL * DW;
   localparam int OUT_DEPTH = 2 ** $clog2(2 * MAX_KERNEL);
   localparam int OCW = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_PAD = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [mfz_pkg::WIDTH_REG_W-1:0] width_ff;
   logic [mfz_pkg::HEIGHT_REG_W-1:0] height_ff;
   logic [mfz_pkg::SIZE_REG_W-1:0] size_ff;
   logic [mfz_pkg::ANCHOR_REG_W-1:0] anchor_ff;

   logic [CW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [KCW-1:0] k_eff, a_eff, re_eff;

   logic [CW-1:0] in_col_ff, in_col_in;
   logic [HW-1:0] in_row_ff, in_row_in;
   logic [PW-1:0] pad_pos_ff, pad_pos_in;
   logic [KCW-1:0] pad_left_ff, pad_left_in;
   logic [HW-1:0] pad_row_ff, pad_row_in;
   logic [HW-1:0] ey_ff, ey_in, ey_b;
   logic [CW-1:0] ex_ff, ex_in, ex_b;
   logic cmp_ff, cmp_in, cmp_b;

   logic pix_acc, drn_acc, drain_issue, pad_act, room, last_col;
   logic [PW-1:0] pos;
   logic hval;
   logic [AW-1:0] hcol, rd_addr;
   logic [HW-1:0] hrow;
   logic signed [DW-1:0] req_sample, push_sample, hres;
   mfz_pkg::chain_ctrl_type chain_ctrl;

   logic b_valid_ff, b_drain_ff;
   logic [AW-1:0] b_col_ff;
   logic [HW-1:0] b_row_ff;
   logic signed [DW-1:0] b_h_ff;

   logic wr_valid_ff;
   logic [AW-1:0] wr_addr_ff;
   logic [VEC_W-1:0] wr_data_ff, rd_data, old_flat, new_flat;
   logic signed [DW-1:0] old_v [MAX_KERNEL];
   logic signed [DW-1:0] new_v [MAX_KERNEL];
   logic [31:0] drain_j;
   logic emit, emit_last, we;
   logic [HW-1:0] oy;
   logic [CW-1:0] ox;
   logic signed [DW-1:0] ovalue;
   mfz_pkg::out_item_type emit_item, head_item;
   logic [OCW-1:0] fifo_count;

   // Effective configuration.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = CW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(height_ff);
      end
      if (size_ff == '0) begin
         k_eff = KCW'(1);
      end else if (32'(size_ff) > 32'(MAX_KERNEL)) begin
         k_eff = KCW'(MAX_KERNEL);
      end else begin
         k_eff = KCW'(size_ff);
      end
      if (32'(anchor_ff) > 32'(k_eff) - 32'd1) begin
         a_eff = k_eff - 1'b1;
      end else begin
         a_eff = KCW'(anchor_ff);
      end
      re_eff = k_eff - 1'b1 - a_eff;
   end

   // Horizontal stage.
   assign room = (32'(fifo_count) + 32'(b_valid_ff)) <= 32'(OUT_DEPTH - MAX_KERNEL);
   assign req_tready = (state_ff == ST_IDLE) && room;
   assign pix_acc = req_tvalid && req_tready && !req_tuser[0];
   assign drn_acc = req_tvalid && req_tready && req_tuser[0];
   assign pad_act = (state_ff == ST_PAD);
   assign last_col = (in_col_ff == w_eff - 1'b1);

   assign req_sample = $signed(req_tdata);
   assign push_sample = pad_act ? mfz_pkg::ZERO_Q14 :
                        ((req_sample > mfz_pkg::ONE_Q14) ? mfz_pkg::ONE_Q14 : req_sample);
   assign chain_ctrl.push = pix_acc || pad_act;
   assign chain_ctrl.row_start = pix_acc && (in_col_ff == '0);

   mfz_row_chain #(
      .MAX_KERNEL(MAX_KERNEL),
      .KW        (KW)
   ) u_row_chain (
      .clock     (clock),
      .ctrl      (chain_ctrl),
      .sample    (push_sample),
      .length_sel(KW'(k_eff - 1'b1)),
      .result    (hres)
   );

   assign pos = pad_act ? pad_pos_ff : PW'(in_col_ff);
   assign hval = chain_ctrl.push && (32'(pos) >= 32'(re_eff));
   assign hcol = AW'(pos - PW'(re_eff));
   assign hrow = pad_act ? pad_row_ff : in_row_ff;
   assign drain_issue = drn_acc && cmp_b;
   assign rd_addr = drain_issue ? AW'(ex_b) : hcol;

   mfz_ram #(
      .WIDTH(VEC_W),
      .DEPTH(MAX_WIDTH),
      .AW   (AW)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (we),
      .wr_addr   (b_col_ff),
      .wr_data   (new_flat),
      .rd_en     (hval || drain_issue),
      .rd_addr   (rd_addr),
      .rd_data_ff(rd_data)
   );

   // Vertical stage: each line store word holds the running column minima.
   always_comb begin
      if (!b_drain_ff && (b_row_ff == '0)) begin
         old_flat = '0;
      end else if (wr_valid_ff && (wr_addr_ff == b_col_ff)) begin
         old_flat = wr_data_ff;
      end else begin
         old_flat = rd_data;
      end
   end

   for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_vcell
      assign old_v[j] = $signed(old_flat[j*DW +: DW]);
      if (j == 0) begin : g_first
         assign new_v[j] = b_h_ff;
      end else begin : g_rest
         assign new_v[j] = mfz_pkg::min_q14(b_h_ff, old_v[j-1]);
      end
      assign new_flat[j*DW +: DW] = new_v[j];
   end

   assign drain_j = 32'(h_eff) - 32'd1 - 32'(b_row_ff) + 32'(a_eff);
   assign we = b_valid_ff && !b_drain_ff;
   assign emit = b_valid_ff && (b_drain_ff || (32'(b_row_ff) >= 32'(re_eff)));
   assign oy = b_drain_ff ? b_row_ff : b_row_ff - HW'(re_eff);
   assign ox = CW'(b_col_ff);
   assign ovalue = b_drain_ff ? mfz_pkg::min_q14(mfz_pkg::ZERO_Q14, old_v[KW'(drain_j)])
                              : new_v[KW'(k_eff - 1'b1)];
   assign emit_last = (oy == h_eff - 1'b1) && (ox == w_eff - 1'b1);

   assign emit_item.last_pixel = emit_last;
   assign emit_item.out_column = mfz_pkg::COL_W'(ox);
   assign emit_item.out_row = mfz_pkg::ROW_W'(oy);
   assign emit_item.out_value = ovalue;

   always_comb begin
      ey_b = ey_ff;
      ex_b = ex_ff;
      cmp_b = cmp_ff;
      if (emit) begin
         if (emit_last) begin
            ey_b = '0;
            ex_b = '0;
            cmp_b = 1'b0;
         end else if (ox == w_eff - 1'b1) begin
            ey_b = oy + 1'b1;
            ex_b = '0;
         end else begin
            ey_b = oy;
            ex_b = ox + 1'b1;
         end
      end
   end

   // Sequencing of input position, row-end padding and output index.
   always_comb begin
      state_in = state_ff;
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      pad_pos_in = pad_pos_ff;
      pad_left_in = pad_left_ff;
      pad_row_in = pad_row_ff;
      ey_in = ey_b;
      ex_in = ex_b;
      cmp_in = cmp_b;
      unique case (state_ff)
         ST_IDLE: begin
            if (pix_acc) begin
               if (cmp_b) begin
                  ey_in = '0;
                  ex_in = '0;
                  cmp_in = 1'b0;
               end
               if (last_col) begin
                  in_col_in = '0;
                  if (in_row_ff == h_eff - 1'b1) begin
                     in_row_in = '0;
                     cmp_in = 1'b1;
                  end else begin
                     in_row_in = in_row_ff + 1'b1;
                  end
                  if (re_eff != '0) begin
                     state_in = ST_PAD;
                     pad_pos_in = PW'(w_eff);
                     pad_left_in = re_eff;
                     pad_row_in = in_row_ff;
                  end
               end else begin
                  in_col_in = in_col_ff + 1'b1;
               end
            end
         end
         ST_PAD: begin
            pad_pos_in = pad_pos_ff + 1'b1;
            pad_left_in = pad_left_ff - 1'b1;
            if (pad_left_ff == KCW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_write_enable) begin
         in_col_in = '0;
         in_row_in = '0;
         ey_in = '0;
         ex_in = '0;
         cmp_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         width_ff <= mfz_pkg::WIDTH_RESET;
         height_ff <= mfz_pkg::HEIGHT_RESET;
         size_ff <= mfz_pkg::SIZE_RESET;
         anchor_ff <= mfz_pkg::ANCHOR_RESET;
         in_col_ff <= '0;
         in_row_ff <= '0;
         pad_left_ff <= '0;
         ey_ff <= '0;
         ex_ff <= '0;
         cmp_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         pad_left_ff <= pad_left_in;
         ey_ff <= ey_in;
         ex_ff <= ex_in;
         cmp_ff <= cmp_in;
         b_valid_ff <= hval || drain_issue;
         wr_valid_ff <= we;
         if (csr_write_enable) begin
            unique case (mfz_pkg::csr_index_type'(csr_index))
               mfz_pkg::REG_IMAGE_WIDTH: begin
                  width_ff <= mfz_pkg::WIDTH_REG_W'(csr_wdata);
               end
               mfz_pkg::REG_IMAGE_HEIGHT: begin
                  height_ff <= mfz_pkg::HEIGHT_REG_W'(csr_wdata);
               end
               mfz_pkg::REG_WINDOW_SIZE: begin
                  size_ff <= mfz_pkg::SIZE_REG_W'(csr_wdata);
               end
               mfz_pkg::REG_WINDOW_ANCHOR: begin
                  anchor_ff <= mfz_pkg::ANCHOR_REG_W'(csr_wdata);
               end
               default: begin
                  width_ff <= width_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pad_pos_ff <= pad_pos_in;
      pad_row_ff <= pad_row_in;
      b_drain_ff <= drain_issue;
      b_col_ff <= rd_addr;
      b_row_ff <= drain_issue ? ey_b : hrow;
      b_h_ff <= hres;
      wr_addr_ff <= b_col_ff;
      wr_data_ff <= new_flat;
   end

   mfz_out_fifo #(
      .DEPTH(OUT_DEPTH),
      .CNT_W(OCW)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_item (emit_item),
      .pop_ready (rsp_tready),
      .head_valid(rsp_tvalid),
      .head_item (head_item),
      .count     (fifo_count)
   );

   assign rsp_tdata = {4'b0000, head_item.out_column, head_item.out_row, head_item.out_value};
   assign rsp_tlast = head_item.last_pixel;

endmodule

// File: src/mfz_checker.sv
// Port-level checks on the minimum filter, bound to its top level.
// Depends on mfz_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mfz_checker (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [mfz_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic rsp_tlast
);

   `MFZ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result item withdrawn")
   `MFZ_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result item changed")
   `MFZ_ASSERT_NOW(a_value_max, clock, reset, rsp_tvalid, $signed(rsp_tdata[15:0]) <= $signed(mfz_pkg::ONE_Q14), "filtered value above one")
   `MFZ_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "result pending after reset")

endmodule

bind min_filter_2d_zero_border mfz_checker u_mfz_checker (.*);
